// ----- rtl/lmb_pkg.sv -----
package lmb_pkg;

  // Default sizing of the frame and window storage.
  localparam int DEF_MAX_WIDTH       = 1024;
  localparam int DEF_MAX_HEIGHT      = 1024;
  localparam int DEF_MAX_HALF_WINDOW = 15;

  // Fixed field widths.
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 10;
  localparam int DIM_W     = 11;
  localparam int THR_W     = 8;
  localparam int HWIN_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  // Register values after reset.
  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = DIM_W'(480);
  localparam logic [THR_W-1:0]  RST_THRESHOLD    = THR_W'(26);
  localparam logic [HWIN_W-1:0] RST_HALF_WINDOW  = HWIN_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_THRESHOLD    = 2'd2,
    REG_HALF_WINDOW  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    F_IDLE,
    F_DIV
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SETUP,
    B_CNT,
    B_SWEEP,
    B_DRAIN,
    B_MUL,
    B_OUT
  } back_state_t;

  // Status from the back part to the front part.
  typedef struct packed {
    logic take;       // job register is taken this cycle
    logic done_pend;  // the job at work closes a frame
  } lmb_bstat_t;

endpackage

// ----- rtl/lmb_ram.sv -----
module lmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/lmb_div.sv -----
module lmb_div #(
  parameter int NW = 21,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial    = {rem_r, quo_r[NW-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/lmb_front.sv -----
module lmb_front #(
  parameter int MAX_WIDTH       = lmb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = lmb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_HALF_WINDOW = lmb_pkg::DEF_MAX_HALF_WINDOW,
  localparam int X_W    = $clog2(MAX_WIDTH),
  localparam int Y_W    = $clog2(MAX_HEIGHT),
  localparam int CW     = $clog2(MAX_WIDTH + 1),
  localparam int HTW    = $clog2(MAX_HEIGHT + 1),
  localparam int HW     = $clog2(MAX_HALF_WINDOW + 1),
  localparam int RING_W = $clog2(2 * MAX_HALF_WINDOW + 2),
  localparam int AW     = RING_W + X_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic                     mode,
  input  logic [lmb_pkg::PIX_W-1:0] pixel,
  output logic                     full,
  input  logic [CW-1:0]            w,
  input  logic [HTW-1:0]           ht,
  input  logic [HW-1:0]            h,
  input  lmb_pkg::lmb_bstat_t      bstat,
  output logic                     job_vld,
  output logic [X_W-1:0]           job_ox,
  output logic [Y_W-1:0]           job_oy,
  output logic                     job_done,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [lmb_pkg::PIX_W-1:0] wr_data
);

  localparam int RW = $clog2(MAX_HEIGHT + 2 * MAX_HALF_WINDOW + 2);
  localparam int PW = $clog2(MAX_WIDTH * (MAX_HEIGHT + 2 * MAX_HALF_WINDOW + 2));

  lmb_pkg::front_state_t state_r, state_nxt;
  logic [X_W-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0]  in_row_r, in_row_nxt;
  logic           done_r, done_nxt;
  logic           job_vld_r, job_vld_nxt;
  logic [X_W-1:0] job_ox_r, job_ox_nxt;
  logic [Y_W-1:0] job_oy_r, job_oy_nxt;

  logic             accept;
  logic             wrap;
  logic [X_W-1:0]   col0, col_a, col_n;
  logic [RW-1:0]    row0, row_a, row_n;
  logic [RW+CW-1:0] p_mul;
  logic [CW+HTW-1:0] tot_mul;
  logic [HW+CW-1:0] lag_mul;
  logic [PW-1:0]    p_raw, p, total, lag, last, qv;
  logic             restart, in_frame, ignore, report, done_now;
  logic [CW-1:0]    col_inc;
  logic [RW+RING_W-1:0] row_ext;
  logic             div_done;
  logic [PW-1:0]    div_quo;
  logic [CW-1:0]    div_rem;
  logic [PW+Y_W-1:0] quo_ext;
  logic [CW+X_W-1:0] rem_ext;

  assign full   = (state_r != lmb_pkg::F_IDLE) || job_vld_r || bstat.done_pend;
  assign accept = push && !full;

  always_comb begin
    wrap    = (CW'(in_col_r) >= w);
    col0    = wrap ? '0 : in_col_r;
    row0    = wrap ? '0 : in_row_r;
    p_mul   = row0 * w;
    tot_mul = w * ht;
    lag_mul = h * w;
    p_raw   = PW'(p_mul) + PW'(col0);
    total   = PW'(tot_mul);
    lag     = PW'(lag_mul) + PW'(h);
    last    = total - PW'(1) + lag;
    restart = (p_raw > last);
    col_a   = restart ? '0 : col0;
    row_a   = restart ? '0 : row0;
    p       = restart ? '0 : p_raw;
    in_frame = (p < total);
    ignore  = in_frame && mode;
    report  = !ignore && (p >= lag);
    done_now = (p == last);
    qv      = p - lag;
    col_inc = CW'(col_a) + CW'(1);
    if (col_inc >= w) begin
      col_n = '0;
      row_n = row_a + 1'b1;
    end else begin
      col_n = X_W'(col_inc);
      row_n = row_a;
    end
    row_ext = {{RING_W{1'b0}}, row_a};
  end

  assign wr_en   = accept && in_frame && !mode;
  assign wr_addr = {row_ext[RING_W-1:0], col_a};
  assign wr_data = pixel;

  lmb_div #(
    .NW (PW),
    .DW (CW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && report),
    .num   (qv),
    .den   (w),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    quo_ext     = {{Y_W{1'b0}}, div_quo};
    rem_ext     = {{X_W{1'b0}}, div_rem};
    state_nxt   = state_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    done_nxt    = done_r;
    job_vld_nxt = job_vld_r;
    job_ox_nxt  = job_ox_r;
    job_oy_nxt  = job_oy_r;
    if (bstat.take) begin
      job_vld_nxt = 1'b0;
    end
    case (state_r)
      lmb_pkg::F_IDLE: begin
        if (accept) begin
          if (ignore) begin
            in_col_nxt = col_a;
            in_row_nxt = row_a;
          end else if (report && done_now) begin
            in_col_nxt = '0;
            in_row_nxt = '0;
          end else begin
            in_col_nxt = col_n;
            in_row_nxt = row_n;
          end
          if (report) begin
            done_nxt  = done_now;
            state_nxt = lmb_pkg::F_DIV;
          end
        end
      end
      lmb_pkg::F_DIV: begin
        if (div_done) begin
          job_vld_nxt = 1'b1;
          job_ox_nxt  = rem_ext[X_W-1:0];
          job_oy_nxt  = quo_ext[Y_W-1:0];
          state_nxt   = lmb_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = lmb_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lmb_pkg::F_IDLE;
      in_col_r  <= '0;
      in_row_r  <= '0;
      job_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      job_vld_r <= job_vld_nxt;
    end
    done_r   <= done_nxt;
    job_ox_r <= job_ox_nxt;
    job_oy_r <= job_oy_nxt;
  end

  assign job_vld  = job_vld_r;
  assign job_ox   = job_ox_r;
  assign job_oy   = job_oy_r;
  assign job_done = done_r;

endmodule

// ----- rtl/lmb_back.sv -----
module lmb_back #(
  parameter int MAX_WIDTH       = lmb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = lmb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_HALF_WINDOW = lmb_pkg::DEF_MAX_HALF_WINDOW,
  localparam int X_W    = $clog2(MAX_WIDTH),
  localparam int Y_W    = $clog2(MAX_HEIGHT),
  localparam int CW     = $clog2(MAX_WIDTH + 1),
  localparam int HTW    = $clog2(MAX_HEIGHT + 1),
  localparam int HW     = $clog2(MAX_HALF_WINDOW + 1),
  localparam int RING_W = $clog2(2 * MAX_HALF_WINDOW + 2),
  localparam int AW     = RING_W + X_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_vld,
  input  logic [X_W-1:0]              job_ox,
  input  logic [Y_W-1:0]              job_oy,
  input  logic                        job_done,
  output lmb_pkg::lmb_bstat_t         bstat,
  input  logic [CW-1:0]               w,
  input  logic [HTW-1:0]              ht,
  input  logic [HW-1:0]               h,
  input  logic [lmb_pkg::THR_W-1:0]   thr,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [lmb_pkg::PIX_W-1:0]   rd_data,
  input  logic                        pop,
  output logic                        out_vld,
  output logic [lmb_pkg::COORD_W-1:0] out_x,
  output logic [lmb_pkg::COORD_W-1:0] out_y,
  output logic                        out_white,
  output logic                        out_done
);

  localparam int WIN   = 2 * MAX_HALF_WINDOW + 1;
  localparam int SIDEW = $clog2(WIN + 1);
  localparam int CNTW  = $clog2(WIN * WIN + 1);
  localparam int SW    = lmb_pkg::PIX_W + CNTW;
  localparam int LW    = lmb_pkg::PIX_W + CNTW;
  localparam int RHW   = SW + lmb_pkg::THR_W + 1;
  localparam int CMPW  = RHW;

  lmb_pkg::back_state_t state_r, state_nxt;
  logic [X_W-1:0]  ox_r, ox_nxt, x0_r, x0_nxt, x1_r, x1_nxt, sx_r, sx_nxt;
  logic [Y_W-1:0]  oy_r, oy_nxt, y0_r, y0_nxt, y1_r, y1_nxt, sy_r, sy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]   sum_r, sum_nxt;
  logic [lmb_pkg::PIX_W-1:0] ctr_r, ctr_nxt;
  logic            rv_r, rv_nxt, rc_r, rc_nxt;
  logic [LW-1:0]   lhs_r, lhs_nxt;
  logic [RHW-1:0]  rhs_r, rhs_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic [lmb_pkg::COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic            out_white_r, out_white_nxt, out_done_r, out_done_nxt;

  logic [X_W:0]    ox_e, hx, wx, xs;
  logic [Y_W:0]    oy_e, hy, hty, ys;
  logic [SIDEW-1:0] dx, dy;
  logic [2*SIDEW-1:0] cnt_mul;
  logic [Y_W+RING_W-1:0] sy_ext;
  logic [X_W+lmb_pkg::COORD_W-1:0] ox_ext;
  logic [Y_W+lmb_pkg::COORD_W-1:0] oy_ext;
  logic [CMPW-1:0] lhs_cmp, rhs_cmp;
  logic            take;

  always_comb begin
    ox_e    = {1'b0, ox_r};
    oy_e    = {1'b0, oy_r};
    hx      = (X_W + 1)'(h);
    hy      = (Y_W + 1)'(h);
    wx      = (X_W + 1)'(w);
    hty     = (Y_W + 1)'(ht);
    xs      = ox_e + hx;
    ys      = oy_e + hy;
    dx      = SIDEW'(x1_r - x0_r) + SIDEW'(1);
    dy      = SIDEW'(y1_r - y0_r) + SIDEW'(1);
    cnt_mul = dx * dy;
    sy_ext  = {{RING_W{1'b0}}, sy_r};
    ox_ext  = {{lmb_pkg::COORD_W{1'b0}}, ox_r};
    oy_ext  = {{lmb_pkg::COORD_W{1'b0}}, oy_r};
    lhs_cmp = CMPW'({lhs_r, 8'd0});
    rhs_cmp = CMPW'(rhs_r);
  end

  assign take    = (state_r == lmb_pkg::B_IDLE) && job_vld;
  assign rd_en   = (state_r == lmb_pkg::B_SWEEP);
  assign rd_addr = {sy_ext[RING_W-1:0], sx_r};

  always_comb begin
    state_nxt     = state_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    done_nxt      = done_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    ctr_nxt       = ctr_r;
    rv_nxt        = 1'b0;
    rc_nxt        = 1'b0;
    lhs_nxt       = lhs_r;
    rhs_nxt       = rhs_r;
    out_vld_nxt   = out_vld_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_white_nxt = out_white_r;
    out_done_nxt  = out_done_r;

    if (pop && out_vld_r) begin
      out_vld_nxt = 1'b0;
    end
    // Read data lands in the cycle after the address.
    if (rv_r) begin
      sum_nxt = sum_r + SW'(rd_data);
      if (rc_r) begin
        ctr_nxt = rd_data;
      end
    end

    case (state_r)
      lmb_pkg::B_IDLE: begin
        if (job_vld) begin
          ox_nxt    = job_ox;
          oy_nxt    = job_oy;
          done_nxt  = job_done;
          state_nxt = lmb_pkg::B_SETUP;
        end
      end
      lmb_pkg::B_SETUP: begin
        x0_nxt    = (ox_e >= hx) ? X_W'(ox_e - hx) : '0;
        y0_nxt    = (oy_e >= hy) ? Y_W'(oy_e - hy) : '0;
        x1_nxt    = (xs < wx) ? X_W'(xs) : X_W'(wx - 1'b1);
        y1_nxt    = (ys < hty) ? Y_W'(ys) : Y_W'(hty - 1'b1);
        state_nxt = lmb_pkg::B_CNT;
      end
      lmb_pkg::B_CNT: begin
        cnt_nxt   = CNTW'(cnt_mul);
        sum_nxt   = '0;
        sx_nxt    = x0_r;
        sy_nxt    = y0_r;
        state_nxt = lmb_pkg::B_SWEEP;
      end
      lmb_pkg::B_SWEEP: begin
        rv_nxt = 1'b1;
        rc_nxt = (sx_r == ox_r) && (sy_r == oy_r);
        if (sx_r == x1_r) begin
          sx_nxt = x0_r;
          if (sy_r == y1_r) begin
            state_nxt = lmb_pkg::B_DRAIN;
          end else begin
            sy_nxt = sy_r + 1'b1;
          end
        end else begin
          sx_nxt = sx_r + 1'b1;
        end
      end
      lmb_pkg::B_DRAIN: begin
        state_nxt = lmb_pkg::B_MUL;
      end
      lmb_pkg::B_MUL: begin
        lhs_nxt   = LW'(ctr_r) * LW'(cnt_r);
        rhs_nxt   = RHW'(sum_r) * RHW'(9'd256 - {1'b0, thr});
        state_nxt = lmb_pkg::B_OUT;
      end
      lmb_pkg::B_OUT: begin
        if (!out_vld_r || pop) begin
          out_vld_nxt   = 1'b1;
          out_x_nxt     = ox_ext[lmb_pkg::COORD_W-1:0];
          out_y_nxt     = oy_ext[lmb_pkg::COORD_W-1:0];
          out_white_nxt = (lhs_cmp >= rhs_cmp);
          out_done_nxt  = done_r;
          state_nxt     = lmb_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = lmb_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lmb_pkg::B_IDLE;
      rv_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rv_r      <= rv_nxt;
      out_vld_r <= out_vld_nxt;
    end
    ox_r        <= ox_nxt;
    oy_r        <= oy_nxt;
    done_r      <= done_nxt;
    x0_r        <= x0_nxt;
    x1_r        <= x1_nxt;
    y0_r        <= y0_nxt;
    y1_r        <= y1_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    cnt_r       <= cnt_nxt;
    sum_r       <= sum_nxt;
    ctr_r       <= ctr_nxt;
    rc_r        <= rc_nxt;
    lhs_r       <= lhs_nxt;
    rhs_r       <= rhs_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_white_r <= out_white_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign bstat.take      = take;
  assign bstat.done_pend = (state_r != lmb_pkg::B_IDLE) && done_r;
  assign out_vld         = out_vld_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_white       = out_white_r;
  assign out_done        = out_done_r;

endmodule

// ----- rtl/local_mean_binarizer_core.sv -----
// An item that reports a pixel has its raster index divided in the front, PW being the
// raster index width (21 at default size); the job is then handed over to the back, which
// sweeps the clipped window and reads one window pixel per cycle. The front can accept
// a new item while the back works on the last job, but not while it is dividing or holds
// a job not yet taken. Reset is synchronous: it restores the configuration registers, the
// control state and the raster cursor; the row store is not cleared.
module local_mean_binarizer_core #(
  parameter int MAX_WIDTH       = lmb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = lmb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_HALF_WINDOW = lmb_pkg::DEF_MAX_HALF_WINDOW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel: a transaction is push while not full.
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_mode,
  input  logic [lmb_pkg::PIX_W-1:0]     in_pixel,
  // Result channel: a transaction is pop while not empty.
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [lmb_pkg::COORD_W-1:0]   out_x,
  output logic [lmb_pkg::COORD_W-1:0]   out_y,
  output logic                          out_is_white,
  output logic                          out_frame_done,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [lmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmb_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int CW     = $clog2(MAX_WIDTH + 1);
  localparam int HTW    = $clog2(MAX_HEIGHT + 1);
  localparam int HW     = $clog2(MAX_HALF_WINDOW + 1);
  localparam int RING_W = $clog2(2 * MAX_HALF_WINDOW + 2);
  localparam int AW     = RING_W + X_W;

  logic [lmb_pkg::DIM_W-1:0]  image_width_r, image_width_nxt;
  logic [lmb_pkg::DIM_W-1:0]  image_height_r, image_height_nxt;
  logic [lmb_pkg::THR_W-1:0]  threshold_r, threshold_nxt;
  logic [lmb_pkg::HWIN_W-1:0] half_window_r, half_window_nxt;

  logic [CW-1:0]  w;
  logic [HTW-1:0] ht;
  logic [HW-1:0]  h;

  lmb_pkg::lmb_bstat_t bstat;
  logic            job_vld, job_done;
  logic [X_W-1:0]  job_ox;
  logic [Y_W-1:0]  job_oy;
  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [lmb_pkg::PIX_W-1:0] wr_data, rd_data;
  logic            out_vld;

  // Register writes. Configuration should only change while the block is idle; the block does not enforce this.
  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    threshold_nxt    = threshold_r;
    half_window_nxt  = half_window_r;
    if (cfg_we) begin
      case (lmb_pkg::cfg_idx_t'(cfg_index))
        lmb_pkg::REG_IMAGE_WIDTH:  image_width_nxt  = cfg_data;
        lmb_pkg::REG_IMAGE_HEIGHT: image_height_nxt = cfg_data;
        lmb_pkg::REG_THRESHOLD:    threshold_nxt    = cfg_data[lmb_pkg::THR_W-1:0];
        lmb_pkg::REG_HALF_WINDOW:  half_window_nxt  = cfg_data[lmb_pkg::HWIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= lmb_pkg::RST_IMAGE_WIDTH;
      image_height_r <= lmb_pkg::RST_IMAGE_HEIGHT;
      threshold_r    <= lmb_pkg::RST_THRESHOLD;
      half_window_r  <= lmb_pkg::RST_HALF_WINDOW;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
      threshold_r    <= threshold_nxt;
      half_window_r  <= half_window_nxt;
    end
  end

  // The sizes in use are the register values clamped to what the storage holds.
  always_comb begin
    if (image_width_r == '0) begin
      w = CW'(1);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(image_width_r);
    end
    if (image_height_r == '0) begin
      ht = HTW'(1);
    end else if (32'(image_height_r) > MAX_HEIGHT) begin
      ht = HTW'(MAX_HEIGHT);
    end else begin
      ht = HTW'(image_height_r);
    end
    if (32'(half_window_r) > MAX_HALF_WINDOW) begin
      h = HW'(MAX_HALF_WINDOW);
    end else begin
      h = HW'(half_window_r);
    end
  end

  // The front tracks the raster cursor, stores pixels and turns the cursor into the
  // coordinate of the pixel to report. It holds at most one job for the back, and it
  // holds off a new frame until the frame's last report has left the back, so that new
  // rows never overwrite a window still being summed.
  lmb_front #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .mode     (in_mode),
    .pixel    (in_pixel),
    .full     (in_full),
    .w        (w),
    .ht       (ht),
    .h        (h),
    .bstat    (bstat),
    .job_vld  (job_vld),
    .job_ox   (job_ox),
    .job_oy   (job_oy),
    .job_done (job_done),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  // Row store: a ring of rows, indexed by the low row bits and the column.
  lmb_ram #(
    .WIDTH (lmb_pkg::PIX_W),
    .DEPTH (2 ** AW)
  ) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The back sweeps the clipped window, sums it, and compares
  // center * count * 256 against sum * (256 - threshold).
  lmb_back #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_vld   (job_vld),
    .job_ox    (job_ox),
    .job_oy    (job_oy),
    .job_done  (job_done),
    .bstat     (bstat),
    .w         (w),
    .ht        (ht),
    .h         (h),
    .thr       (threshold_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .pop       (out_pop),
    .out_vld   (out_vld),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_white (out_is_white),
    .out_done  (out_frame_done)
  );

  assign out_empty = !out_vld;

endmodule
